// ----- rtl/core/srtp_rw_pkg.sv -----
package srtp_rw_pkg;

  localparam int SeqW        = 16;
  localparam int RocW        = 32;
  localparam int IndexW      = RocW + SeqW;
  localparam int DeltaW      = 18;
  localparam int HalfRange   = 32768;
  localparam int SeqSpan     = 65536;
  localparam int WindowSizeDefault = 64;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSecurity = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInitRoc  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInitSeq  = 2'd2;

  typedef struct packed {
    logic            action;
    logic [SeqW-1:0] sequence_number;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [IndexW-1:0] packet_index;
    logic [RocW-1:0]   rollover_count;
  } out_item_t;

  // State loads requested by configuration writes.
  typedef struct packed {
    logic            roc_load;
    logic            seq_load;
    logic [RocW-1:0] roc;
    logic [SeqW-1:0] seq;
  } cfg_load_t;

  // Index estimate for the item in the work stage.
  typedef struct packed {
    logic                     advance;
    logic signed [DeltaW-1:0] delta;
    logic [RocW-1:0]          guess;
    logic [RocW-1:0]          roc_after;
  } est_t;

endpackage

// ----- rtl/core/srtp_index_estimate_replay_window_unit.sv -----
// SRTP packet index estimation with an anti-replay window.
//
// Input channel (in_valid/in_ready/in_item): one item per RTP packet, carrying
// the 16-bit sequence number and an action bit (0 checks only, 1 checks and
// commits the packet into the replay state). Output channel (out_valid/
// out_ready/out_item): one item per input item, in order, with the accept
// flag, the estimated 48-bit packet index and the rollover count after the step.
//
// An accepted item is registered into the work stage, worked on there, and
// its result is registered into the output register. The unit takes one
// item per cycle while the receiver keeps up; the rollover count, highest
// sequence and seen mask are read and updated in the work stage as the item
// moves on, so consecutive items always see each other's commits.
//
// When the receiver stalls, the result stays in the output register and the
// work stage holds its item; in_ready drops only once both are full.
// Reset clears both stages, the security flag, the rollover count, the highest
// sequence and the window. Configuration writes through cfg_we/cfg_index/
// cfg_data take effect at the edge and are expected only while the unit is idle.
module srtp_index_estimate_replay_window_unit import srtp_rw_pkg::*; #(
  parameter int WINDOW_SIZE = WindowSizeDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_fire;
  logic      commit;
  logic      security_enabled;
  logic      accepted;
  cfg_load_t load;
  est_t      est;

  // The work stage moves on whenever the output register is free or draining.
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign commit   = s1_fire && s1_item.action;

  // Register decode. A write to the starting roc also clears the window.
  always_comb begin
    load.roc_load = cfg_we && (cfg_index == RegInitRoc);
    load.seq_load = cfg_we && (cfg_index == RegInitSeq);
    load.roc      = cfg_data[RocW-1:0];
    load.seq      = cfg_data[SeqW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      security_enabled <= 1'b0;
    end else if (cfg_we && (cfg_index == RegSecurity)) begin
      security_enabled <= cfg_data[0];
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  srtp_rw_index u_index (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .commit (commit),
    .seq    (s1_item.sequence_number),
    .est    (est)
  );

  srtp_rw_window #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_window (
    .clk              (clk),
    .rst              (rst),
    .clear            (load.roc_load),
    .security_enabled (security_enabled),
    .commit           (commit),
    .est              (est),
    .accepted         (accepted)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item.accepted       <= accepted;
      out_item.packet_index   <= {est.guess, s1_item.sequence_number};
      out_item.rollover_count <= est.roc_after;
    end
  end

  a_open_accept: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !security_enabled) |=> out_item.accepted)
    else $error("item rejected with security off");

  a_index_low: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_item.packet_index[SeqW-1:0] == $past(s1_item.sequence_number))
    else $error("packet index low half differs from the sequence number");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> s1_valid && $stable(s1_item))
    else $error("work stage lost a stalled item");

endmodule

// ----- rtl/core/srtp_rw_index.sv -----
module srtp_rw_index import srtp_rw_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_load_t       load,
  input  logic            commit,
  input  logic [SeqW-1:0] seq,
  output est_t            est
);

  logic [RocW-1:0]          stored_roc;
  logic [SeqW-1:0]          highest_seq;
  logic signed [DeltaW-1:0] diff;
  logic                     dec;
  logic                     inc;

  // Half-range test picks roc-1, roc or roc+1.
  always_comb begin
    diff = $signed({2'b00, seq}) - $signed({2'b00, highest_seq});
    dec  = !highest_seq[SeqW-1] && (diff > DeltaW'(HalfRange));
    inc  = highest_seq[SeqW-1] && ({1'b0, highest_seq[SeqW-2:0]} > seq);
    est.guess = stored_roc;
    est.delta = diff;
    if (dec) begin
      est.guess = stored_roc - RocW'(1);
      est.delta = diff - DeltaW'(SeqSpan);
    end else if (inc) begin
      est.guess = stored_roc + RocW'(1);
      est.delta = diff + DeltaW'(SeqSpan);
    end
    est.advance   = est.delta > DeltaW'(0);
    est.roc_after = (commit && est.advance) ? est.guess : stored_roc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_roc  <= '0;
      highest_seq <= '0;
    end else begin
      if (load.roc_load) begin
        stored_roc <= load.roc;
      end else if (commit && est.advance) begin
        stored_roc <= est.guess;
      end
      if (load.seq_load) begin
        highest_seq <= load.seq;
      end else if (commit && est.advance) begin
        highest_seq <= seq;
      end
    end
  end

  a_seq_advance: assert property (@(posedge clk) disable iff (rst)
    (commit && est.advance && !load.seq_load) |=> highest_seq == $past(seq))
    else $error("highest sequence did not follow a forward commit");

endmodule

// ----- rtl/core/srtp_rw_window.sv -----
module srtp_rw_window import srtp_rw_pkg::*; #(
  parameter int WINDOW_SIZE = WindowSizeDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic security_enabled,
  input  logic commit,
  input  est_t est,
  output logic accepted
);

  localparam int IdxW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  logic [WINDOW_SIZE-1:0] seen_mask;
  logic [WINDOW_SIZE-1:0] seen_mask_next;
  logic [DeltaW-1:0]      back;
  logic                   in_win;
  logic                   far_ahead;
  logic [IdxW-1:0]        bit_idx;
  logic [IdxW-1:0]        shift;

  always_comb begin
    back      = DeltaW'(-est.delta);
    in_win    = !est.advance && (back < DeltaW'(WINDOW_SIZE));
    far_ahead = est.delta >= DeltaW'(WINDOW_SIZE);
    bit_idx   = back[IdxW-1:0];
    shift     = est.delta[IdxW-1:0];
    accepted  = !security_enabled || est.advance || (in_win && !seen_mask[bit_idx]);

    seen_mask_next = seen_mask;
    if (clear) begin
      seen_mask_next = '0;
    end else if (commit) begin
      if (est.advance) begin
        seen_mask_next = (far_ahead ? '0 : (seen_mask << shift)) | WINDOW_SIZE'(1);
      end else if (in_win) begin
        seen_mask_next = seen_mask | (WINDOW_SIZE'(1) << bit_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_mask <= '0;
    end else begin
      seen_mask <= seen_mask_next;
    end
  end

  a_newest_marked: assert property (@(posedge clk) disable iff (rst)
    (commit && est.advance && !clear) |=> seen_mask[0])
    else $error("newest packet not marked in the window");

endmodule

// ----- tb/srtp_replay_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels and the register port of the replay-window unit.
// Keeps its own copy of the rollover count, highest sequence and seen window,
// and compares every result leaving the unit with the oldest prediction.
module srtp_replay_checker import srtp_rw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatches,
  output int                  pending
);

  localparam int WinSize = WindowSizeDefault;

  logic             sec_on;
  logic [RocW-1:0]  roc_q;
  logic [SeqW-1:0]  top_seq;
  logic [63:0]      seen_bits;
  out_item_t        due_q[$];
  int               bad_fields;

  assign mismatches = bad_fields;

  // Works out the result of one packet and applies its commit, if any.
  function automatic out_item_t estimate_and_commit(in_item_t it);
    int              off;
    int              delta;
    int              back;
    logic [RocW-1:0] guess;
    out_item_t       res;
    off = 0;
    if (top_seq < HalfRange) begin
      if (int'(it.sequence_number) - int'(top_seq) > HalfRange) off = -1;
    end else if (int'(top_seq) - HalfRange > int'(it.sequence_number)) begin
      off = 1;
    end
    guess = roc_q + off;
    delta = off * SeqSpan + int'(it.sequence_number) - int'(top_seq);
    back = -delta;
    res.packet_index = {guess, it.sequence_number};
    if (delta > 0) res.accepted = 1'b1;
    else if (back >= WinSize) res.accepted = 1'b0;
    else res.accepted = !seen_bits[back];
    if (!sec_on) res.accepted = 1'b1;
    // The commit flag is the single action bit.
    if (it.action) begin
      if (delta > 0) begin
        seen_bits = (delta >= WinSize) ? '0 : seen_bits << delta;
        seen_bits[0] = 1'b1;
        roc_q = guess;
        top_seq = it.sequence_number;
      end else if (back < WinSize) begin
        seen_bits[back] = 1'b1;
      end
    end
    res.rollover_count = roc_q;
    return res;
  endfunction

  initial bad_fields = 0;

  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst) begin
      sec_on = 1'b0;
      roc_q = '0;
      top_seq = '0;
      seen_bits = '0;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegSecurity: sec_on = cfg_data[0];
          RegInitRoc: begin
            roc_q = cfg_data[RocW-1:0];
            seen_bits = '0;
          end
          RegInitSeq: top_seq = cfg_data[SeqW-1:0];
          default: ;
        endcase
      end
      // Results leave only after their packet has been registered, so compare first.
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("result with nothing expected: index %h", out_item.packet_index);
          bad_fields++;
        end else begin
          exp_res = due_q.pop_front();
          if (out_item.accepted !== exp_res.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_res.accepted, out_item.accepted);
            bad_fields++;
          end
          if (out_item.packet_index !== exp_res.packet_index) begin
            $error("packet_index: expected %h, got %h",
                   exp_res.packet_index, out_item.packet_index);
            bad_fields++;
          end
          if (out_item.rollover_count !== exp_res.rollover_count) begin
            $error("rollover_count: expected %h, got %h",
                   exp_res.rollover_count, out_item.rollover_count);
            bad_fields++;
          end
        end
      end
      if (in_valid && in_ready) due_q.push_back(estimate_and_commit(in_item));
    end
    pending <= due_q.size();
  end

endmodule

// ----- tb/tb_srtp_index_estimate_replay_window_unit.sv -----
`timescale 1ns / 1ps

module tb_srtp_index_estimate_replay_window_unit;
  import srtp_rw_pkg::*;

  // Action bit of an input item.
  localparam logic ActCheck  = 1'b0;
  localparam logic ActCommit = 1'b1;
  // The index port is two bits wide, so one index maps to no register.
  localparam logic [CfgIdxW-1:0] RegNone = 2'd3;
  // Length of the one long stall on the result side, in cycles.
  localparam int LongHold = 80;
  localparam int Phases = 6;
  localparam int PhaseItems = 140;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_item;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int                  mismatches;
  int                  pending;
  int                  results_seen = 0;
  bit                  calm = 1'b0;
  bit                  held = 1'b0;
  // Highest sequence number the stream generator believes is committed.
  logic [SeqW-1:0]     stream_seq;

  always #2 clk = ~clk;

  srtp_index_estimate_replay_window_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  srtp_replay_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Count results so the receiver knows when to start its long stall.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) results_seen <= results_seen + 1;
  end

  // Offers one item, sometimes after an idle burst, and returns at the edge
  // where the unit takes it. The valid line is not dropped between items
  // unless an idle burst is inserted.
  task automatic offer(input logic act, input logic [SeqW-1:0] seq);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{action: act, sequence_number: seq};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted result has come out.
  // The extra cycles let the pipeline settle before any register write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the security flag, optionally the rollover count (which also
  // clears the window), the highest sequence, and the unmapped index.
  // Bits above each register's width carry random junk.
  task automatic load_state(input logic sec, input logic [RocW-1:0] roc,
                            input logic [SeqW-1:0] hs, input bit with_roc);
    logic [31:0] junk;
    junk = $urandom;
    cfg_we <= 1'b1;
    cfg_index <= RegSecurity;
    cfg_data <= {junk[31:1], sec};
    @(posedge clk);
    if (with_roc) begin
      cfg_index <= RegInitRoc;
      cfg_data <= roc;
      @(posedge clk);
    end
    cfg_index <= RegInitSeq;
    cfg_data <= {junk[15:0], hs};
    @(posedge clk);
    cfg_index <= RegNone;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    stream_seq = hs;
  endtask

  // One packet of a mostly plausible RTP stream: small steps forward, late
  // and duplicate packets, gaps around the window edge, jumps near half the
  // sequence range, and the odd random number.
  task automatic stream_item();
    int              pick;
    logic            act;
    logic [SeqW-1:0] seq;
    logic [SeqW-1:0] step;
    pick = $urandom_range(0, 99);
    act = ($urandom_range(0, 3) != 0) ? ActCommit : ActCheck;
    if (pick < 55) seq = SeqW'(stream_seq + $urandom_range(1, 3));
    else if (pick < 72) seq = SeqW'(stream_seq - $urandom_range(0, 70));
    else if (pick < 82) seq = SeqW'(stream_seq + $urandom_range(4, 90));
    else if (pick < 90) seq = SeqW'(stream_seq + $urandom_range(32700, 32840));
    else seq = SeqW'($urandom);
    step = seq - stream_seq;
    if (act == ActCommit && step != 0 && step < 16'h8000) stream_seq = seq;
    offer(act, seq);
  endtask

  // Result side: random stall and ready bursts, one long stall once enough
  // results have come so the unit backs up, and steady ready at the end.
  initial begin
    forever begin
      if (!held && results_seen >= 200) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    int              p;
    logic            sec;
    logic [RocW-1:0] roc;
    logic [SeqW-1:0] hs;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= RegSecurity;
    cfg_data <= '0;
    stream_seq = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Security is off after reset, so every packet must be accepted, and a
    // commit still moves the state. A sequence of all ones against a highest
    // sequence of zero guesses one rollover back, and the guessed count wraps.
    offer(ActCheck, 16'h0000);
    offer(ActCommit, 16'hFFFF);
    offer(ActCheck, 16'h8000);
    offer(ActCommit, 16'h8000);
    drain();

    // Count at its maximum, highest sequence near the top: the next small
    // sequence guesses one rollover ahead and the count wraps to zero.
    load_state(1'b1, 32'hFFFF_FFFF, 16'hFFF0, 1'b1);
    offer(ActCheck, 16'd5);
    offer(ActCommit, 16'd5);
    offer(ActCheck, 16'd5);        // replay of a committed packet
    offer(ActCommit, 16'd5);       // duplicate commit
    offer(ActCheck, 16'hFFF0);     // late packet from the previous rollover
    offer(ActCommit, 16'hFFF0);
    offer(ActCheck, 16'hFFF0);
    offer(ActCheck, 16'hFFC6);     // oldest position still inside the window
    offer(ActCheck, 16'hFFC5);     // just outside the window
    offer(ActCommit, 16'hFFC5);    // too old, commit leaves the window alone
    offer(ActCommit, 16'd68);      // shift by one less than the window
    offer(ActCommit, 16'd200);     // shift past the window clears it
    drain();

    // Highest sequence on either side of the half-range boundary.
    load_state(1'b1, 32'h0000_0000, 16'h7FFF, 1'b1);
    offer(ActCheck, 16'hFFFF);
    offer(ActCommit, 16'h0000);
    drain();
    load_state(1'b1, 32'h0000_0000, 16'h8000, 1'b1);
    offer(ActCheck, 16'h0000);
    offer(ActCommit, 16'hFFFF);
    drain();

    // Reload the highest sequence only, keeping the window, and commit a
    // packet from one rollover back with the count at zero.
    load_state(1'b1, 32'h0000_0000, 16'h0010, 1'b0);
    offer(ActCommit, 16'hFFF0);
    offer(ActCheck, 16'hFFF0);

    for (p = 0; p < Phases; p++) begin
      drain();
      sec = (p == 1) ? 1'b0 : ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 4))
        0: roc = 32'h0000_0000;
        1: roc = 32'hFFFF_FFFF;
        2: roc = 32'h0000_0001;
        3: roc = 32'hFFFF_FFFE;
        default: roc = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: hs = 16'h0000;
        1: hs = 16'hFFFF;
        default: hs = SeqW'($urandom);
      endcase
      load_state(sec, roc, hs, $urandom_range(0, 3) != 0);
      // The last phase runs with no idling on either side.
      if (p == Phases - 1) calm = 1'b1;
      repeat (PhaseItems) stream_item();
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
